// ----- design/sha_pkg.sv -----
// Shared types and constants for the SHA-256 stream hasher.
// Holds round constants, initial hash values and controller command/status structs.
package sha_pkg;

    localparam logic [1:0] ACT_BYTE        = 2'd0;
    localparam logic [1:0] ACT_BYTE_FINISH = 2'd1;
    localparam logic [1:0] ACT_FINISH      = 2'd2;
    localparam logic [1:0] ACT_UNDEF       = 2'd3;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam int unsigned LEN_POS  = 56;

    typedef struct packed {
        logic       put_byte;    // write byte at pos
        logic [7:0] put_data;
        logic [5:0] put_pos;
        logic       put_len;     // write length words 14/15
        logic       cnt_inc;
        logic       cnt_clr;
        logic       comp_start;  // load schedule and working vars
        logic       round;       // execute one round
        logic       comp_done;   // add working vars into hash
        logic       hash_iv;     // reload initial values
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] pos;         // byte_count mod 64
        logic [5:0] round_idx;
    } t_dp_stat;

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        logic [31:0] v;
        unique case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ----- design/sha_datapath.sv -----
// Datapath: block buffer, byte counter, message schedule, round logic, hash state.
// Depends on sha_pkg. Driven by sha_ctrl through t_dp_cmd.
module sha_datapath import sha_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_dp_cmd        i_cmd,
    input  logic [2:0]     i_rd_idx,
    output t_dp_stat       o_stat,
    output logic [31:0]    o_hash_word
);

    logic [31:0] r_blk   [16];
    logic [31:0] r_w     [16];
    logic [31:0] r_v     [8];
    logic [31:0] r_h     [8];
    logic [60:0] r_cnt;
    logic [5:0]  r_rnd;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] x2, x15, g0, g1, w_new, wt, s0, s1, ch, mj, t1, t2;
    logic [3:0]  slot;
    logic [3:0]  wi;
    logic [1:0]  bi;

    assign slot = r_rnd[3:0];
    assign x2   = r_w[4'(slot - 4'd2)];
    assign x15  = r_w[4'(slot - 4'd15)];
    assign g1   = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    assign g0   = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    assign w_new = g1 + r_w[4'(slot - 4'd7)] + g0 + r_w[slot];
    assign wt   = (r_rnd >= 6'd16) ? w_new : r_w[slot];
    assign s1   = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1   = r_v[7] + s1 + ch + ROUND_K[r_rnd] + wt;
    assign s0   = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign mj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2   = s0 + mj;

    assign wi = i_cmd.put_pos[5:2];
    assign bi = i_cmd.put_pos[1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_byte) begin
            unique case (bi)
                2'd0: r_blk[wi] <= {i_cmd.put_data, 24'd0};
                2'd1: r_blk[wi][23:16] <= i_cmd.put_data;
                2'd2: r_blk[wi][15:8]  <= i_cmd.put_data;
                default: r_blk[wi][7:0] <= i_cmd.put_data;
            endcase
        end
        if (i_cmd.put_len) begin
            r_blk[14] <= r_cnt[60:29];
            r_blk[15] <= {r_cnt[28:0], 3'd0};
        end
        if (i_cmd.comp_start) begin
            for (int i = 0; i < 16; i++) r_w[i] <= r_blk[i];
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round) begin
            r_w[slot] <= wt;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.hash_iv) begin
            for (int i = 0; i < 8; i++) r_h[i] <= iv_word(3'(i));
        end else if (i_cmd.comp_done) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rnd <= '0;
        end else begin
            if (i_cmd.cnt_clr) r_cnt <= '0;
            else if (i_cmd.cnt_inc) r_cnt <= r_cnt + 61'd1;
            if (i_cmd.comp_start) r_rnd <= '0;
            else if (i_cmd.round) r_rnd <= r_rnd + 6'd1;
        end
    end

    assign o_stat.pos       = r_cnt[5:0];
    assign o_stat.round_idx = r_rnd;
    assign o_hash_word      = r_h[i_rd_idx];

endmodule

// ----- design/sha_ctrl.sv -----
// Controller: sequences byte loads, padding, compressions and digest output.
// Depends on sha_pkg; commands sha_datapath through t_dp_cmd.
module sha_ctrl import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  t_dp_stat    i_stat,
    output t_dp_cmd     o_cmd,
    output logic [2:0]  o_rd_idx,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,  // compression loading
        ST_ROUND = 7'b0000100,
        ST_ADD   = 7'b0001000,
        ST_PAD   = 7'b0010000,  // 0x80 and zero-fill toward length field
        ST_LEN   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic       r_fin, n_fin;       // finish pending after compression
    logic       r_final, n_final;   // compression in flight is the last one
    logic [5:0] r_pos, n_pos;       // padding position
    logic [2:0] r_idx, n_idx;
    // Set when padding wrapped into a second block: zero-fill of the next one.
    logic       r_pad_wrap, n_pad_wrap;

    logic acc;
    assign o_stall = (r_state != ST_IDLE);
    assign acc     = i_valid && !o_stall && (i_action != ACT_UNDEF);

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_final = r_final;
        n_pos   = r_pos;
        n_idx   = r_idx;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (i_action != ACT_FINISH) begin
                        o_cmd.put_byte = 1'b1;
                        o_cmd.put_data = i_data_byte;
                        o_cmd.put_pos  = i_stat.pos;
                        o_cmd.cnt_inc  = 1'b1;
                    end
                    n_fin = (i_action != ACT_BYTE);
                    priority if (i_action != ACT_FINISH && i_stat.pos == 6'd63) begin
                        n_final = 1'b0;
                        n_state = ST_LOAD;
                    end else if (i_action != ACT_BYTE) begin
                        n_pos   = (i_action == ACT_FINISH) ? i_stat.pos : 6'(i_stat.pos + 6'd1);
                        n_state = ST_PAD;
                        // 0x80 goes into the first pad slot
                        n_final = 1'b0;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.put_byte = 1'b1;
                o_cmd.put_pos  = r_pos;
                o_cmd.put_data = r_fin ? PAD_BYTE : 8'd0;
                n_fin = 1'b0;
                n_pos = 6'(r_pos + 6'd1);
                // r_fin marks the 0x80 byte; afterwards fill zeros
                if (r_pos == 6'd63) begin
                    n_final = 1'b0;
                    n_state = ST_LOAD;
                end else if (r_pos == 6'(LEN_POS - 1)) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                o_cmd.put_len = 1'b1;
                n_final = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.comp_start = 1'b1;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_stat.round_idx == 6'd63) n_state = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.comp_done = 1'b1;
                priority if (r_final) begin
                    n_idx   = '0;
                    n_state = ST_OUT;
                end else if (r_fin) begin
                    n_pos   = 6'd0;  // byte after last full block, 0x80 at 0
                    n_state = ST_PAD;
                end else if (r_pad_wrap) begin
                    n_pos   = 6'd0;
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_idx = 3'(r_idx + 3'd1);
                    if (r_idx == 3'd7) begin
                        o_cmd.hash_iv = 1'b1;
                        o_cmd.cnt_clr = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_pad_wrap = r_pad_wrap;
        if (r_state == ST_PAD && r_pos == 6'd63) n_pad_wrap = 1'b1;
        if (r_state == ST_ADD) n_pad_wrap = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fin      <= 1'b0;
            r_final    <= 1'b0;
            r_pos      <= '0;
            r_idx      <= '0;
            r_pad_wrap <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fin      <= n_fin;
            r_final    <= n_final;
            r_pos      <= n_pos;
            r_idx      <= n_idx;
            r_pad_wrap <= n_pad_wrap;
        end
    end

    assign o_rd_idx     = r_idx;
    assign o_valid      = (r_state == ST_OUT);
    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == 3'd7);

endmodule

// ----- design/sha256_stream_hasher_core.sv -----
// SHA-256 over a byte stream; one byte per input transfer, eight digest words out.
// Input: a byte is taken whenever idle; every 64th byte starts a compression, stalling input.
// Finish: padding fill, then one or two compressions, then the digest words out.
// Throughput: one round per cycle in the shared round unit sets the compression time.
// Reset: synchronous active-low; hash state returns to the initial values.
module sha256_stream_hasher_core import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_dp_cmd    cmd;
    t_dp_stat   stat;
    logic [2:0] rd_idx;

    sha_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_action, .i_data_byte,
        .i_stat(stat), .o_cmd(cmd), .o_rd_idx(rd_idx),
        .o_valid, .i_stall, .o_word_index, .o_last_word
    );

    sha_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_rd_idx(rd_idx),
        .o_stat(stat), .o_hash_word(o_digest_word)
    );

`ifndef ASSERT_OFF
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last_word mismatch");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken during output");
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_word_index != 3'd7) |=>
            (o_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("word index skipped");
`endif

endmodule

// ----- test/tb_sha256_stream_hasher_core.sv -----
// Testbench for sha256_stream_hasher_core: byte-stream SHA-256 with padding and digest output.
// Depends on sha_pkg for action codes and round constants; predicts digests in a scoreboard class.
module tb_sha256_stream_hasher_core;
    import sha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    class digest_scoreboard;
        logic [31:0] hash_st [8];
        logic [31:0] blk [16];
        logic [60:0] nbytes;
        logic [31:0] want_word [$];
        logic [2:0]  want_idx [$];
        logic        want_last [$];
        int          errors;
        int          digests;

        function new();
            errors = 0;
            digests = 0;
            clear_msg();
        endfunction

        function void clear_msg();
            for (int i = 0; i < 8; i++) hash_st[i] = iv_word(i[2:0]);
            for (int i = 0; i < 16; i++) blk[i] = '0;
            nbytes = '0;
        endfunction

        function logic [31:0] rr(logic [31:0] v, int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] v [8];
            logic [31:0] x2, x15, t1, t2, wt;
            for (int i = 0; i < 16; i++) w[i] = blk[i];
            for (int i = 0; i < 8; i++) v[i] = hash_st[i];
            for (int r = 0; r < 64; r++) begin
                if (r >= 16) begin
                    x2 = w[(r - 2) & 15];
                    x15 = w[(r - 15) & 15];
                    w[r & 15] = (rr(x2, 17) ^ rr(x2, 19) ^ (x2 >> 10)) + w[(r - 7) & 15]
                              + (rr(x15, 7) ^ rr(x15, 18) ^ (x15 >> 3)) + w[r & 15];
                end
                wt = w[r & 15];
                t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wt;
                t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hash_st[i] += v[i];
        endfunction

        function void place(int pos, logic [7:0] b);
            if ((pos & 3) == 0) blk[pos >> 2] = '0;
            blk[pos >> 2] |= {24'd0, b} << (24 - 8 * (pos & 3));
        endfunction

        // note an accepted input transfer
        function void note_input(logic [1:0] act, logic [7:0] b);
            logic [63:0] bits;
            int pos;
            if (act == ACT_UNDEF) return;
            if (act == ACT_BYTE || act == ACT_BYTE_FINISH) begin
                pos = int'(nbytes[5:0]);
                place(pos, b);
                nbytes++;
                if (pos == 63) compress();
            end
            if (act == ACT_BYTE) return;
            bits = {nbytes, 3'b000};
            pos = int'(nbytes[5:0]);
            place(pos, PAD_BYTE);
            pos++;
            if (pos > LEN_POS) begin
                while (pos < 64) begin place(pos, 8'h00); pos++; end
                compress();
                pos = 0;
            end
            while (pos < LEN_POS) begin place(pos, 8'h00); pos++; end
            blk[14] = bits[63:32];
            blk[15] = bits[31:0];
            compress();
            for (int k = 0; k < 8; k++) begin
                want_word = {want_word, hash_st[k]};
                want_idx  = {want_idx, k[2:0]};
                want_last = {want_last, (k == 7)};
            end
            clear_msg();
        endfunction

        // check one accepted output transfer
        function void check_word(logic [31:0] dw, logic [2:0] idx, logic last);
            if (want_word.size() == 0) begin
                $display("%0t: unexpected digest word %h idx %0d", $time, dw, idx);
                errors++;
                return;
            end
            if (dw !== want_word[0] || idx !== want_idx[0] || last !== want_last[0]) begin
                $display("%0t: mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                         want_word[0], want_idx[0], want_last[0], dw, idx, last);
                errors++;
            end
            if (last === 1'b1) digests++;
            void'(want_word.pop_front());
            void'(want_idx.pop_front());
            void'(want_last.pop_front());
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_action = ACT_BYTE;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    digest_scoreboard sb = new();
    bit hold_off = 1'b0;
    int idle_cycles = 0;
    int n_items = 0;

    sha256_stream_hasher_core dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // monitor: sample at rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (i_valid && !o_stall) begin
                sb.note_input(i_action, i_data_byte);
                idle_cycles = 0;
            end
            if (o_valid && !i_stall) begin
                sb.check_word(o_digest_word, o_word_index, o_last_word);
                idle_cycles = 0;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired at %0t", $time);
                $display("sha256_stream_hasher_core test failed");
                $finish;
            end
        end
    end

    // receiver stall pattern
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    i_stall <= 1'b1;
                    repeat (g) @(negedge i_clk);
                end
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send(logic [1:0] act, logic [7:0] b, bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        n_items++;
    endtask

    task automatic send_msg(int len, int fin_mode, bit gaps);
        // fin_mode 0: last byte with finish, 1: separate finish
        for (int i = 0; i < len; i++) begin
            if (i == len - 1 && fin_mode == 0) send(ACT_BYTE_FINISH, 8'($urandom), gaps);
            else send(ACT_BYTE, 8'($urandom), gaps);
        end
        if (fin_mode == 1 || len == 0) send(ACT_FINISH, 8'($urandom), gaps);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.want_word.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    initial begin
        int len;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty message, byte extremes, undefined action, boundaries
        send(ACT_FINISH, 8'hff, 1'b0);
        send(ACT_UNDEF, 8'h5a, 1'b0);
        send(ACT_BYTE, 8'h00, 1'b0);
        send(ACT_BYTE_FINISH, 8'hff, 1'b0);
        send(ACT_UNDEF, 8'ha5, 1'b0);
        send(ACT_BYTE_FINISH, 8'h80, 1'b0);
        drain();
        send_msg(55, 1, 1'b0);  // pad fits in one block
        send_msg(56, 0, 1'b0);  // pad needs a second block
        drain();

        // long receiver hold-off while the sender keeps pushing
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_msg(3, 0, 1'b0);
                send_msg(2, 1, 1'b0);
                send_msg(1, 0, 1'b0);
            end
        join
        drain();

        while (n_items < 370) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(60, 130);
                1: send(ACT_UNDEF, 8'($urandom), 1'b1);
                2: len = 0;
                default: len = $urandom_range(1, 20);
            endcase
            send_msg(len, $urandom_range(0, 1), 1'b1);
        end
        drain();

        $display("ran %0d input transfers, %0d digests checked, incl. empty, undefined-action",
                 n_items, sb.digests);
        $display("and padding-boundary messages under random stalls and a long hold-off");
        if (sb.errors == 0 && sb.want_word.size() == 0) begin
            $display("sha256_stream_hasher_core test passed");
        end else begin
            $display("sha256_stream_hasher_core test failed");
        end
        $finish;
    end
endmodule
